[rtl/core/i2cts_pkg.sv]
package i2cts_pkg;

	localparam int WRITE_DEPTH = 64;
	localparam int ADDR_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
	localparam int LP_W = $clog2(WRITE_DEPTH + 1);
	localparam int ISS_W = $clog2(WRITE_DEPTH + 256);

	localparam int WLEN_W = 7;
	localparam int RLEN_W = 8;
	localparam int TIMER_W = 20;
	localparam int WORD_W = 10;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 20'd100000;
	localparam logic [WORD_W-1:0] WORD_READ = 10'h100;
	localparam logic [WORD_W-1:0] WORD_STOP = 10'h200;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_POLL  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OUTCOME_NONE    = 2'd0,
		OUTCOME_SUCCESS = 2'd1,
		OUTCOME_ERROR   = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		REG_WRITE_LENGTH = 2'd0,
		REG_READ_LENGTH  = 2'd1,
		REG_IDLE_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [WLEN_W-1:0]  write_length;
		logic [RLEN_W-1:0]  read_length;
		logic [TIMER_W-1:0] idle_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

endpackage

[rtl/core/i2cts_ifs.sv]
interface i2cts_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] load_byte;
	logic [7:0] rx_fifo_data;
	logic       rx_not_empty;
	logic       tx_not_full;
	logic       tx_empty;
	logic       master_active;
	logic       tx_abort;
	logic       tick;

	modport source(output valid, command, load_byte, rx_fifo_data, rx_not_empty,
		tx_not_full, tx_empty, master_active, tx_abort, tick, input ready);
	modport sink(input valid, command, load_byte, rx_fifo_data, rx_not_empty,
		tx_not_full, tx_empty, master_active, tx_abort, tick, output ready);
endinterface

interface i2cts_result_if;
	logic       valid;
	logic       ready;
	logic       fifo_write;
	logic [9:0] fifo_word;
	logic       fifo_read;
	logic [7:0] rx_byte;
	logic [7:0] rx_index;
	logic       finished;
	logic [1:0] outcome;
	logic [7:0] received_count;

	modport source(output valid, fifo_write, fifo_word, fifo_read, rx_byte, rx_index,
		finished, outcome, received_count, input ready);
	modport sink(input valid, fifo_write, fifo_word, fifo_read, rx_byte, rx_index,
		finished, outcome, received_count, output ready);
endinterface

[rtl/core/i2cts_regs.sv]
module i2cts_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [i2cts_pkg::PADDR_W-1:0]  paddr,
	input  logic [i2cts_pkg::PDATA_W-1:0]  pwdata,
	output logic [i2cts_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	output i2cts_pkg::cfg_t                cfg
);

	i2cts_pkg::cfg_t       cfg_q;
	i2cts_pkg::reg_idx_t   idx;
	logic                  wr_en;

	assign idx    = i2cts_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_length       <= '0;
			cfg_q.read_length        <= '0;
			cfg_q.idle_timeout_ticks <= i2cts_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			case (idx)
				i2cts_pkg::REG_WRITE_LENGTH: begin
					cfg_q.write_length <= pwdata[i2cts_pkg::WLEN_W-1:0];
				end
				i2cts_pkg::REG_READ_LENGTH: begin
					cfg_q.read_length <= pwdata[i2cts_pkg::RLEN_W-1:0];
				end
				i2cts_pkg::REG_IDLE_TIMEOUT: begin
					cfg_q.idle_timeout_ticks <= pwdata[i2cts_pkg::TIMER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			i2cts_pkg::REG_WRITE_LENGTH: begin
				prdata = i2cts_pkg::PDATA_W'(cfg_q.write_length);
			end
			i2cts_pkg::REG_READ_LENGTH: begin
				prdata = i2cts_pkg::PDATA_W'(cfg_q.read_length);
			end
			i2cts_pkg::REG_IDLE_TIMEOUT: begin
				prdata = i2cts_pkg::PDATA_W'(cfg_q.idle_timeout_ticks);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

[rtl/core/i2cts_store.sv]
module i2cts_store (
	input  logic                   clk,
	input  i2cts_pkg::store_req_t  req,
	output logic [7:0]             head
);

	logic [7:0] mem [i2cts_pkg::WRITE_DEPTH];
	logic [7:0] head_q;

	assign head = head_q;

	// The read port always fetches the byte for the next command word, so the
	// engine sees it without a read latency. A write to that entry is forwarded.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.we && (req.waddr == req.raddr)) begin
			head_q <= req.wdata;
		end else begin
			head_q <= mem[req.raddr];
		end
	end

endmodule

[rtl/core/i2cts_engine.sv]
module i2cts_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cts_pkg::cfg_t        cfg,
	i2cts_item_if.sink             item,
	i2cts_result_if.source         result,
	output i2cts_pkg::store_req_t  store_req,
	input  logic [7:0]             store_head
);

	// Input register.
	logic                  valid_s1;
	i2cts_pkg::cmd_t       cmd_s1;
	logic [7:0]            load_byte_s1;
	logic [7:0]            rx_data_s1;
	logic                  rx_not_empty_s1;
	logic                  tx_not_full_s1;
	logic                  tx_empty_s1;
	logic                  master_active_s1;
	logic                  tx_abort_s1;
	logic                  tick_s1;

	// Transfer state.
	logic [i2cts_pkg::LP_W-1:0]    load_ptr_q;
	logic [i2cts_pkg::ISS_W-1:0]   issued_q;
	logic [7:0]                    got_q;
	logic [i2cts_pkg::TIMER_W-1:0] timer_q;
	logic                          busy_q;

	logic [i2cts_pkg::LP_W-1:0]    load_ptr_n;
	logic [i2cts_pkg::ISS_W-1:0]   issued_n;
	logic [7:0]                    got_n;
	logic [i2cts_pkg::TIMER_W-1:0] timer_n;
	logic                          busy_n;
	logic                          load_en;

	// Result register.
	logic                          res_valid_q;
	logic                          fifo_write_q;
	logic [i2cts_pkg::WORD_W-1:0]  fifo_word_q;
	logic                          fifo_read_q;
	logic [7:0]                    rx_byte_q;
	logic [7:0]                    rx_index_q;
	logic                          finished_q;
	logic [1:0]                    outcome_q;
	logic [7:0]                    received_count_q;

	logic                          fifo_write_c;
	logic [i2cts_pkg::WORD_W-1:0]  fifo_word_c;
	logic                          fifo_read_c;
	logic [7:0]                    rx_byte_c;
	logic [7:0]                    rx_index_c;
	logic                          finished_c;
	i2cts_pkg::outcome_t           outcome_c;

	logic                          advance;
	logic [i2cts_pkg::ISS_W-1:0]   wlen;
	logic [i2cts_pkg::ISS_W-1:0]   total;
	logic [i2cts_pkg::ISS_W-1:0]   wlen_raw;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	assign wlen_raw = i2cts_pkg::ISS_W'(cfg.write_length);
	assign wlen     = (wlen_raw < i2cts_pkg::ISS_W'(i2cts_pkg::WRITE_DEPTH)) ?
		wlen_raw : i2cts_pkg::ISS_W'(i2cts_pkg::WRITE_DEPTH);
	assign total    = wlen + i2cts_pkg::ISS_W'(cfg.read_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1           <= i2cts_pkg::cmd_t'(item.command);
			load_byte_s1     <= item.load_byte;
			rx_data_s1       <= item.rx_fifo_data;
			rx_not_empty_s1  <= item.rx_not_empty;
			tx_not_full_s1   <= item.tx_not_full;
			tx_empty_s1      <= item.tx_empty;
			master_active_s1 <= item.master_active;
			tx_abort_s1      <= item.tx_abort;
			tick_s1          <= item.tick;
		end
	end

	always_comb begin
		load_ptr_n   = load_ptr_q;
		issued_n     = issued_q;
		got_n        = got_q;
		timer_n      = timer_q;
		busy_n       = busy_q;
		load_en      = 1'b0;
		fifo_write_c = 1'b0;
		fifo_word_c  = '0;
		fifo_read_c  = 1'b0;
		rx_byte_c    = '0;
		rx_index_c   = '0;
		finished_c   = 1'b0;
		outcome_c    = i2cts_pkg::OUTCOME_NONE;
		case (cmd_s1)
			i2cts_pkg::CMD_LOAD: begin
				if (!busy_q && (load_ptr_q < i2cts_pkg::LP_W'(i2cts_pkg::WRITE_DEPTH))) begin
					load_en    = 1'b1;
					load_ptr_n = load_ptr_q + 1'b1;
				end
			end
			i2cts_pkg::CMD_START: begin
				load_ptr_n = '0;
				issued_n   = '0;
				got_n      = '0;
				timer_n    = '0;
				busy_n     = 1'b1;
			end
			i2cts_pkg::CMD_POLL: begin
				if (busy_q) begin
					// The tick is counted before any decision of this poll.
					if (tick_s1 && (timer_q != i2cts_pkg::TIMER_MAX)) begin
						timer_n = timer_q + 1'b1;
					end
					if ((got_q < cfg.read_length) && rx_not_empty_s1) begin
						fifo_read_c = 1'b1;
						rx_byte_c   = rx_data_s1;
						rx_index_c  = got_q;
						got_n       = got_q + 1'b1;
						timer_n     = '0;
					end else if (tx_abort_s1) begin
						finished_c = 1'b1;
						outcome_c  = i2cts_pkg::OUTCOME_ERROR;
						busy_n     = 1'b0;
					end else if (issued_q < total) begin
						if (tx_not_full_s1) begin
							fifo_word_c = (issued_q < wlen) ?
								i2cts_pkg::WORD_W'(store_head) : i2cts_pkg::WORD_READ;
							if ((issued_q + 1'b1) == total) begin
								fifo_word_c = fifo_word_c | i2cts_pkg::WORD_STOP;
							end
							fifo_write_c = 1'b1;
							issued_n     = issued_q + 1'b1;
							timer_n      = '0;
						end else if (!master_active_s1 &&
							(timer_n >= cfg.idle_timeout_ticks)) begin
							finished_c = 1'b1;
							outcome_c  = i2cts_pkg::OUTCOME_ERROR;
							busy_n     = 1'b0;
						end
					end else if (tx_empty_s1 && !master_active_s1) begin
						finished_c = 1'b1;
						outcome_c  = i2cts_pkg::OUTCOME_SUCCESS;
						busy_n     = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		store_req.we    = advance && load_en;
		store_req.waddr = load_ptr_q[i2cts_pkg::ADDR_W-1:0];
		store_req.wdata = load_byte_s1;
		store_req.raddr = advance ? issued_n[i2cts_pkg::ADDR_W-1:0] :
			issued_q[i2cts_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			issued_q   <= '0;
			got_q      <= '0;
			timer_q    <= '0;
			busy_q     <= 1'b0;
		end else if (advance) begin
			load_ptr_q <= load_ptr_n;
			issued_q   <= issued_n;
			got_q      <= got_n;
			timer_q    <= timer_n;
			busy_q     <= busy_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fifo_write_q     <= fifo_write_c;
			fifo_word_q      <= fifo_word_c;
			fifo_read_q      <= fifo_read_c;
			rx_byte_q        <= rx_byte_c;
			rx_index_q       <= rx_index_c;
			finished_q       <= finished_c;
			outcome_q        <= outcome_c;
			received_count_q <= got_n;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.fifo_write     = fifo_write_q;
	assign result.fifo_word      = fifo_word_q;
	assign result.fifo_read      = fifo_read_q;
	assign result.rx_byte        = rx_byte_q;
	assign result.rx_index       = rx_index_q;
	assign result.finished       = finished_q;
	assign result.outcome        = outcome_q;
	assign result.received_count = received_count_q;

endmodule

[rtl/core/i2c_transfer_sequencer_core.sv]
// Sequences a combined I2C write-then-read transfer: load the write bytes, issue a start
// item, then send one poll item per controller status snapshot; each item yields exactly
// one result transaction, which is the command word to push, the receive byte taken,
// the end of the transfer, or no action. The block takes one item every clock while the
// result side accepts its results; each item passes the input register, then the result
// register. The 64-entry write byte memory has one registered read port that always holds
// the byte for the next command word, so no poll waits on a memory read.
module i2c_transfer_sequencer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	i2cts_item_if.sink                     item,
	i2cts_result_if.source                 result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [i2cts_pkg::PADDR_W-1:0]  paddr,
	input  logic [i2cts_pkg::PDATA_W-1:0]  pwdata,
	output logic [i2cts_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);

	i2cts_pkg::cfg_t       cfg;
	i2cts_pkg::store_req_t store_req;
	logic [7:0]            store_head;

	i2cts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cts_store u_store (
		.clk  (clk),
		.req  (store_req),
		.head (store_head)
	);

	i2cts_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.result     (result),
		.store_req  (store_req),
		.store_head (store_head)
	);

endmodule

[rtl/core/i2cts_checker.sv]
module i2cts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       fifo_write,
	input logic [9:0] fifo_word,
	input logic       fifo_read,
	input logic [7:0] rx_byte,
	input logic [7:0] rx_index,
	input logic       finished,
	input logic [1:0] outcome
);

	// A stalled result transaction keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(fifo_word) && $stable(finished))
		else $error("result changed while stalled");

	// A poll does at most one thing.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $countones({fifo_write, fifo_read, finished}) <= 1)
		else $error("more than one action in one result");

	a_finish_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (finished == (outcome != i2cts_pkg::OUTCOME_NONE)))
		else $error("finished and outcome disagree");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (fifo_write || fifo_word == 10'd0) &&
			(fifo_read || (rx_byte == 8'd0 && rx_index == 8'd0)))
		else $error("unused result fields are not zero");

endmodule

bind i2c_transfer_sequencer_core i2cts_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.fifo_write (result.fifo_write),
	.fifo_word  (result.fifo_word),
	.fifo_read  (result.fifo_read),
	.rx_byte    (result.rx_byte),
	.rx_index   (result.rx_index),
	.finished   (result.finished),
	.outcome    (result.outcome)
);

[bench/sequencer_checker.sv]
`timescale 1ns / 100ps

module sequencer_checker
	import i2cts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	i2cts_item_if              item_mon,
	i2cts_result_if            result_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 awaiting,
	output int                 results_checked,
	output int                 words_pushed,
	output int                 bytes_taken,
	output int                 xfers_ok,
	output int                 xfers_failed
);

	typedef struct packed {
		logic              fifo_write;
		logic [WORD_W-1:0] fifo_word;
		logic              fifo_read;
		logic [7:0]        rx_byte;
		logic [7:0]        rx_index;
		logic              finished;
		logic [1:0]        outcome;
		logic [7:0]        received_count;
	} poll_result_t;

	// Shadow of the sequencer and of its registers.
	logic [7:0]         store_q [WRITE_DEPTH];
	int                 load_ptr;
	int                 issued_q;
	int                 got_q;
	logic [TIMER_W-1:0] idle_ticks;
	logic               xfer_busy;
	logic [WLEN_W-1:0]  wlen_q;
	logic [RLEN_W-1:0]  rlen_q;
	logic [TIMER_W-1:0] timeout_q;

	poll_result_t expected_results[$];
	poll_result_t head;
	logic [PDATA_W-1:0] reg_value;

	function automatic poll_result_t advance_sequencer(input logic [1:0] cmd,
			input logic [7:0] load_byte, input logic [7:0] rx_data, input logic rx_ne,
			input logic tx_nf, input logic tx_e, input logic m_act, input logic abort,
			input logic tick);
		poll_result_t r;
		int wlen;
		int total;
		logic [WORD_W-1:0] word;
		r = '0;
		wlen = (int'(wlen_q) < WRITE_DEPTH) ? int'(wlen_q) : WRITE_DEPTH;
		total = wlen + int'(rlen_q);
		if (cmd == CMD_LOAD) begin
			if (!xfer_busy && load_ptr < WRITE_DEPTH) begin
				store_q[load_ptr] = load_byte;
				load_ptr++;
			end
		end else if (cmd == CMD_START) begin
			load_ptr = 0;
			issued_q = 0;
			got_q = 0;
			idle_ticks = '0;
			xfer_busy = 1'b1;
		end else if (cmd == CMD_POLL && xfer_busy) begin
			// The tick counts before any decision of this poll.
			if (tick && idle_ticks != TIMER_MAX)
				idle_ticks++;
			if (got_q < int'(rlen_q) && rx_ne) begin
				r.fifo_read = 1'b1;
				r.rx_byte = rx_data;
				r.rx_index = 8'(got_q);
				got_q++;
				idle_ticks = '0;
			end else if (abort) begin
				r.finished = 1'b1;
				r.outcome = OUTCOME_ERROR;
				xfer_busy = 1'b0;
			end else if (issued_q < total) begin
				if (tx_nf) begin
					word = (issued_q < wlen) ? {2'b00, store_q[issued_q]} : WORD_READ;
					if (issued_q + 1 == total)
						word = word | WORD_STOP;
					r.fifo_write = 1'b1;
					r.fifo_word = word;
					issued_q++;
					idle_ticks = '0;
				end else if (!m_act && idle_ticks >= timeout_q) begin
					r.finished = 1'b1;
					r.outcome = OUTCOME_ERROR;
					xfer_busy = 1'b0;
				end
			end else if (tx_e && !m_act) begin
				r.finished = 1'b1;
				r.outcome = OUTCOME_SUCCESS;
				xfer_busy = 1'b0;
			end
		end
		r.received_count = 8'(got_q);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr = 0;
			issued_q = 0;
			got_q = 0;
			idle_ticks = '0;
			xfer_busy = 1'b0;
			wlen_q = '0;
			rlen_q = '0;
			timeout_q = TIMEOUT_RESET;
			expected_results.delete();
			awaiting = 0;
		end else begin
			if (psel && penable && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_WRITE_LENGTH: reg_value = PDATA_W'(wlen_q);
					REG_READ_LENGTH:  reg_value = PDATA_W'(rlen_q);
					REG_IDLE_TIMEOUT: reg_value = PDATA_W'(timeout_q);
					default:          reg_value = '0;
				endcase
				if (pwrite) begin
					case (reg_idx_t'(paddr[3:2]))
						REG_WRITE_LENGTH: wlen_q = pwdata[WLEN_W-1:0];
						REG_READ_LENGTH:  rlen_q = pwdata[RLEN_W-1:0];
						REG_IDLE_TIMEOUT: timeout_q = pwdata[TIMER_W-1:0];
						default: ;
					endcase
				end else begin
					check_field("prdata", reg_value, prdata);
				end
			end
			if (item_mon.valid && item_mon.ready)
				expected_results.push_back(advance_sequencer(item_mon.command,
					item_mon.load_byte, item_mon.rx_fifo_data, item_mon.rx_not_empty,
					item_mon.tx_not_full, item_mon.tx_empty, item_mon.master_active,
					item_mon.tx_abort, item_mon.tick));
			if (result_mon.valid && result_mon.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction arrived with no item waiting for it");
					fail_count++;
				end else begin
					head = expected_results.pop_front();
					check_field("fifo_write", 32'(head.fifo_write),
						32'(result_mon.fifo_write));
					check_field("fifo_word", 32'(head.fifo_word),
						32'(result_mon.fifo_word));
					check_field("fifo_read", 32'(head.fifo_read),
						32'(result_mon.fifo_read));
					check_field("rx_byte", 32'(head.rx_byte), 32'(result_mon.rx_byte));
					check_field("rx_index", 32'(head.rx_index), 32'(result_mon.rx_index));
					check_field("finished", 32'(head.finished), 32'(result_mon.finished));
					check_field("outcome", 32'(head.outcome), 32'(result_mon.outcome));
					check_field("received_count", 32'(head.received_count),
						32'(result_mon.received_count));
					results_checked++;
					words_pushed += int'(head.fifo_write);
					bytes_taken += int'(head.fifo_read);
					if (head.finished && head.outcome == OUTCOME_SUCCESS)
						xfers_ok++;
					if (head.finished && head.outcome == OUTCOME_ERROR)
						xfers_failed++;
				end
			end
			awaiting = expected_results.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import i2cts_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_PHASES = 6;

	typedef enum {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] load_byte;
		logic [7:0] rx_fifo_data;
		logic       rx_not_empty;
		logic       tx_not_full;
		logic       tx_empty;
		logic       master_active;
		logic       tx_abort;
		logic       tick;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int fail_count;
	int awaiting;
	int results_checked;
	int words_pushed;
	int bytes_taken;
	int xfers_ok;
	int xfers_failed;
	int items_sent = 0;
	int cycle_count = 0;
	int sender_gap_pct = 0;
	int receiver_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	i2cts_item_if item_ch();
	i2cts_result_if result_ch();

	i2c_transfer_sequencer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	sequencer_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_mon(item_ch),
		.result_mon(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(fail_count),
		.awaiting(awaiting),
		.results_checked(results_checked),
		.words_pushed(words_pushed),
		.bytes_taken(bytes_taken),
		.xfers_ok(xfers_ok),
		.xfers_failed(xfers_failed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off when the stimulus asks for it.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	function automatic stim_t poll_item(input logic rx_ne, input logic tx_nf,
			input logic tx_e, input logic m_act, input logic abort, input logic tick,
			input logic [7:0] rx_data);
		stim_t s;
		s = '0;
		s.command = CMD_POLL;
		s.rx_fifo_data = rx_data;
		s.rx_not_empty = rx_ne;
		s.tx_not_full = tx_nf;
		s.tx_empty = tx_e;
		s.master_active = m_act;
		s.tx_abort = abort;
		s.tick = tick;
		return s;
	endfunction

	function automatic stim_t plain_item(input logic [1:0] cmd, input logic [7:0] data);
		stim_t s;
		s = '0;
		s.command = cmd;
		s.load_byte = data;
		return s;
	endfunction

	function automatic stim_t random_item(input int start_pct, input int abort_pct,
			input int txnf_pct, input int rxne_pct);
		stim_t s;
		int r;
		r = $urandom_range(0, 99);
		s.command = CMD_POLL;
		if (r < start_pct)
			s.command = CMD_START;
		else if (r < start_pct + 6)
			s.command = CMD_LOAD;
		else if (r < start_pct + 8)
			s.command = CMD_UNUSED;
		s.load_byte = 8'($urandom);
		s.rx_fifo_data = 8'($urandom);
		s.rx_not_empty = ($urandom_range(0, 99) < rxne_pct);
		s.tx_not_full = ($urandom_range(0, 99) < txnf_pct);
		s.tx_empty = ($urandom_range(0, 99) < 60);
		s.master_active = ($urandom_range(0, 99) < 30);
		s.tx_abort = ($urandom_range(0, 99) < abort_pct);
		s.tick = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input stim_t s);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= s.command;
		item_ch.load_byte <= s.load_byte;
		item_ch.rx_fifo_data <= s.rx_fifo_data;
		item_ch.rx_not_empty <= s.rx_not_empty;
		item_ch.tx_not_full <= s.tx_not_full;
		item_ch.tx_empty <= s.tx_empty;
		item_ch.master_active <= s.master_active;
		item_ch.tx_abort <= s.tx_abort;
		item_ch.tick <= s.tick;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
	endtask

	// Write a register, then read it straight back for the checker to compare.
	task automatic set_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int unsigned wl, input int unsigned rl,
			input int unsigned to);
		set_register(REG_WRITE_LENGTH, PDATA_W'(wl));
		set_register(REG_READ_LENGTH, PDATA_W'(rl));
		set_register(REG_IDLE_TIMEOUT, PDATA_W'(to));
	endtask

	task automatic run_phase(input gap_mode_t mode, input int unsigned wl,
			input int unsigned rl, input int unsigned to, input int n, input int start_pct,
			input int abort_pct, input int txnf_pct, input int rxne_pct,
			input bit long_hold);
		drain();
		configure(wl, rl, to);
		case (mode)
			GAPS_NONE: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 0;
			end
			GAPS_SENDER: begin
				sender_gap_pct = 87;
				receiver_stall_pct = 0;
			end
			GAPS_RECEIVER: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 87;
			end
			default: begin
				sender_gap_pct = 25;
				receiver_stall_pct = 25;
			end
		endcase
		if (long_hold)
			hold_requests++;
		send_item(plain_item(CMD_START, 8'h00));
		repeat (n)
			send_item(random_item(start_pct, abort_pct, txnf_pct, rxne_pct));
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.command = CMD_LOAD;
		item_ch.load_byte = '0;
		item_ch.rx_fifo_data = '0;
		item_ch.rx_not_empty = 1'b0;
		item_ch.tx_not_full = 1'b0;
		item_ch.tx_empty = 1'b0;
		item_ch.master_active = 1'b0;
		item_ch.tx_abort = 1'b0;
		item_ch.tick = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: nothing to write or read, so transfers end on an abort or once the controller is idle.
		send_item(poll_item(1, 1, 1, 1, 1, 1, 8'hFF));
		send_item(plain_item(CMD_UNUSED, 8'hFF));
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(1, 0, 0, 0, 1, 0, 8'h00));
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 1, 8'h00));
		send_item(poll_item(0, 1, 1, 1, 0, 0, 8'h00));
		send_item(poll_item(0, 0, 1, 0, 0, 0, 8'h00));
		drain();

		// Three write bytes and two reads; a receive byte wins over the abort flag.
		configure(3, 2, 2);
		send_item(plain_item(CMD_LOAD, 8'h00));
		send_item(plain_item(CMD_LOAD, 8'hFF));
		send_item(plain_item(CMD_LOAD, 8'h5A));
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(0, 0, 0, 0, 0, 1, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(1, 1, 0, 0, 0, 0, 8'hFF));
		send_item(plain_item(CMD_LOAD, 8'h11));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(1, 1, 0, 0, 1, 0, 8'h80));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(0, 0, 1, 0, 0, 0, 8'h00));
		// Idle timeout with the FIFO full, then a restart in the middle of a transfer.
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(0, 0, 0, 0, 0, 1, 8'h00));
		send_item(poll_item(0, 0, 0, 0, 0, 1, 8'h00));
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(plain_item(CMD_START, 8'h00));
		send_item(poll_item(0, 1, 0, 0, 0, 0, 8'h00));
		send_item(poll_item(0, 0, 0, 0, 1, 0, 8'h00));
		drain();

		// Fill every store entry and overrun it by two, so later reads never hit
		// an unwritten entry.
		repeat (WRITE_DEPTH + 2)
			send_item(plain_item(CMD_LOAD, 8'($urandom)));

		run_phase(GAPS_NONE, 2, 3, 4, 30, 5, 2, 80, 50, 1'b1);
		run_phase(GAPS_SENDER, 5, 1, 0, 30, 5, 3, 40, 50, 1'b0);
		run_phase(GAPS_RECEIVER, 0, 6, 1, 30, 5, 2, 50, 50, 1'b0);
		run_phase(GAPS_BOTH, 127, 0, TIMER_MAX, 50, 1, 1, 85, 50, 1'b0);
		run_phase(GAPS_NONE, 64, 80, TIMEOUT_RESET, 260, 0, 0, 100, 55, 1'b0);
		run_phase(GAPS_BOTH, 1, 2, 2, 30, 5, 3, 70, 50, 1'b0);
		drain();
		repeat (8)
			@(posedge clk);

		$display("Sent %0d items: directed cases, a store fill and %0d random phases;",
			items_sent, RANDOM_PHASES);
		$display("compared %0d results: %0d words pushed, %0d bytes received, %0d %s",
			results_checked, words_pushed, bytes_taken, xfers_ok + xfers_failed,
			"transfers ended by success, abort or timeout.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
